[rtl/pbu_pkg.sv]
// Shared types and constants for the pixel blend unit.
`default_nettype none

package pbu_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LANE_W   = 2;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned AMOUNT_W = 17;
   localparam int unsigned CSR_IDX_W = 2;

   // Blend mode codes; code 7 is unused and passes the top byte through
   typedef enum logic [MODE_W-1:0] {
      MODE_MULTIPLY = 3'd0,
      MODE_SUBTRACT = 3'd1,
      MODE_SCREEN   = 3'd2,
      MODE_OVERLAY  = 3'd3,
      MODE_CH_SCALE = 3'd4,
      MODE_CH_ADD   = 3'd5,
      MODE_CH_REPL  = 3'd6
   } mode_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_CHANNEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMOUNT         = 2'd2;

   // Reset values
   localparam logic [MODE_W-1:0]          MODE_RESET   = 3'd0;
   localparam logic [LANE_W-1:0]          TARGET_RESET = 2'd0;
   localparam logic signed [AMOUNT_W-1:0] AMOUNT_RESET = 17'sd256;

   // Rounding offsets in the halved divide-by-510 form
   localparam logic [16:0] ROUND_HALF  = 17'd127;
   localparam logic [16:0] SCREEN_BASE = 17'd65152;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [LANE_W-1:0]          target;
      logic signed [AMOUNT_W-1:0] amount;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/pbu_blend.sv]
// Combinational blend datapath: one shared multiplier and divide-by-255 network.
`default_nettype none

module pbu_blend
   import pbu_pkg::*;
(
   input  wire cfg_type             cfg,
   input  wire logic [BYTE_W-1:0]   top_byte,
   input  wire logic [BYTE_W-1:0]   bottom_byte,
   input  wire logic [LANE_W-1:0]   lane_position,
   output logic      [BYTE_W-1:0]   result_byte
);

   logic signed [AMOUNT_W-1:0] mul_x;
   logic        [BYTE_W-1:0]   mul_y;
   logic signed [25:0]         product;
   logic        [BYTE_W-1:0]   inv_top;
   logic        [BYTE_W-1:0]   inv_bot;
   logic                       use_screen_form;
   logic        [16:0]         half_num;
   logic        [16:0]         quot_sum;
   logic        [BYTE_W-1:0]   blend_q;
   logic signed [25:0]         scale_t;
   logic        [BYTE_W-1:0]   scale_q;
   logic signed [17:0]         add_t;
   logic        [BYTE_W-1:0]   add_q;
   logic        [BYTE_W-1:0]   sub_q;
   logic                       hit;

   assign inv_top = 8'hFF - top_byte;
   assign inv_bot = 8'hFF - bottom_byte;
   assign hit     = (lane_position == cfg.target);

   // Select multiplier operands per mode; overlay doubles the bottom term
   always_comb begin
      mul_x           = signed'({9'd0, top_byte});
      mul_y           = bottom_byte;
      use_screen_form = 1'b0;
      unique case (cfg.mode)
         MODE_SCREEN: begin
            mul_x           = signed'({9'd0, inv_top});
            mul_y           = inv_bot;
            use_screen_form = 1'b1;
         end
         MODE_OVERLAY: begin
            if (bottom_byte[7]) begin
               mul_x           = signed'({9'd0, inv_top});
               mul_y           = {inv_bot[6:0], 1'b0};
               use_screen_form = 1'b1;
            end else begin
               mul_y = {bottom_byte[6:0], 1'b0};
            end
         end
         MODE_CH_SCALE: begin
            mul_x = cfg.amount;
            mul_y = top_byte;
         end
         default: begin
         end
      endcase
   end

   assign product = mul_x * signed'({1'b0, mul_y});

   // Halved numerator, then floor divide by 255 with shifts and adds
   assign half_num = use_screen_form ? (SCREEN_BASE - product[16:0])
                                     : (product[16:0] + ROUND_HALF);
   assign quot_sum = half_num + {8'd0, half_num[16:8]} + 17'd1;
   assign blend_q  = quot_sum[15:8];

   // Channel scale: add one half, truncate, saturate
   assign scale_t = product + 26'sd128;
   always_comb begin
      if (scale_t[25]) begin
         scale_q = '0;
      end else if (scale_t[24:16] != 9'd0) begin
         scale_q = 8'hFF;
      end else begin
         scale_q = scale_t[15:8];
      end
   end

   // Channel add: offset plus byte in Q8.8, saturate
   assign add_t = signed'({cfg.amount[AMOUNT_W-1], cfg.amount})
                + signed'({2'b00, top_byte, 8'h00});
   always_comb begin
      if (add_t[17]) begin
         add_q = '0;
      end else if (add_t[16]) begin
         add_q = 8'hFF;
      end else begin
         add_q = add_t[15:8];
      end
   end

   assign sub_q = (bottom_byte > top_byte) ? (bottom_byte - top_byte) : '0;

   // Pick the result for the active mode
   always_comb begin
      result_byte = top_byte;
      unique case (cfg.mode) inside
         MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY: result_byte = blend_q;
         MODE_SUBTRACT: result_byte = sub_q;
         MODE_CH_SCALE: result_byte = hit ? scale_q : top_byte;
         MODE_CH_ADD:   result_byte = hit ? add_q : top_byte;
         MODE_CH_REPL:  result_byte = hit ? bottom_byte : top_byte;
         default:       result_byte = top_byte;
      endcase
   end

endmodule

`default_nettype wire

[rtl/pixel_blend_unit_core.sv]
// Top level of the pixel blend unit: request register, blend datapath, result register.
`default_nettype none

// Channel   Direction  Handshake        Payload
// req       in         valid / stall    top_byte, bottom_byte, lane_position
// rsp       out        valid / stall    result_byte
// csr       in         valid / ready    index, data (write only)
//
// One request per cycle sustained while rsp_stall is low; a request passes from the request
// register through the blend datapath to the result register, which raises rsp_valid.
// The blend datapath between the request register and the result register is
// one shared multiplier followed by an add-based divide by 255.
// Reset is synchronous, active high, and restores the register defaults.
// A stalled result holds; the request register keeps filling until both stages are full.

module pixel_blend_unit_core
   import pbu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_top_byte,
   input  wire logic [BYTE_W-1:0]     req_bottom_byte,
   input  wire logic [LANE_W-1:0]     req_lane_position,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [BYTE_W-1:0]     rsp_result_byte,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [AMOUNT_W-1:0]   csr_data
);

   cfg_type             cfg_ff;
   logic                s1_valid_ff;
   logic [BYTE_W-1:0]   s1_top_ff;
   logic [BYTE_W-1:0]   s1_bot_ff;
   logic [LANE_W-1:0]   s1_lane_ff;
   logic                out_valid_ff;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic [BYTE_W-1:0]   out_byte_in;
   logic                out_en;
   logic                s1_en;

   assign csr_ready = 1'b1;

   // Write configuration registers; ignore unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= MODE_RESET;
         cfg_ff.target <= TARGET_RESET;
         cfg_ff.amount <= AMOUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BLEND_MODE:     cfg_ff.mode   <= csr_data[MODE_W-1:0];
            CSR_TARGET_CHANNEL: cfg_ff.target <= csr_data[LANE_W-1:0];
            CSR_AMOUNT:         cfg_ff.amount <= signed'(csr_data);
            default: begin
            end
         endcase
      end
   end

   // Advance stages when the next one can take data
   assign out_en    = !out_valid_ff || !rsp_stall;
   assign s1_en     = !s1_valid_ff || out_en;
   assign req_stall = !s1_en;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && req_valid) begin
         s1_top_ff  <= req_top_byte;
         s1_bot_ff  <= req_bottom_byte;
         s1_lane_ff <= req_lane_position;
      end
   end

   pbu_blend u_blend (
      .cfg           (cfg_ff),
      .top_byte      (s1_top_ff),
      .bottom_byte   (s1_bot_ff),
      .lane_position (s1_lane_ff),
      .result_byte   (out_byte_in)
   );

   // Result register; hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s1_valid_ff) begin
         out_byte_ff <= out_byte_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_byte = out_byte_ff;

endmodule

`default_nettype wire
